[rtl/min_priority_queue_coords_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the min-priority queue checker
// Each macro wraps one clocked implication that is disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MIN_PRIORITY_QUEUE_COORDS_ASSERT_SVH
`define MIN_PRIORITY_QUEUE_COORDS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpq: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpq: next-cycle check failed");

// Consequent must hold later than the antecedent, after a delay.
`define MPQ_ASSERT_AFTER2(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("mpq: two-cycle check failed");

`endif

[rtl/mpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants of the min-priority queue: field widths,
// operation codes, result status codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int COORD_W  = 8;
    localparam int COST_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 7;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_PUSH       = 3'd1,
        OP_POP        = 3'd2,
        OP_PUSH_FULL  = 3'd3,
        OP_POP_EMPTY  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_ctrl_cmd;

    typedef struct packed {
        logic action;
        logic full;
        logic empty;
    } t_dp_status;

endpackage

[rtl/min_priority_queue_coords.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_priority_queue_coords
// Bounded min-priority queue of (x, y, cost) entries held sorted by cost in a
// shift array; push inserts in order, pop returns the lowest-cost entry.
// ----------------------------------------------------------------------------
//
//  channel   | handshake               | payload
//  ----------+-------------------------+----------------------------------------
//  command   | start, busy (in)        | i_action, i_coord_x, i_coord_y, i_cost
//  result    | o_done strobe (out)     | o_out_x, o_out_y, o_out_cost, o_status,
//            |                         | o_occupancy, o_is_empty
//
//  Each command passes the capture edge, then an execute cycle in which
//  every cell compares its cost with the new one in parallel and the whole
//  array shifts at once. o_done rises the cycle after execute, and a new
//  command may transfer in that same cycle; no command is taken while one
//  executes. busy is high only during the execute cycle.
//  Reset (i_rst_n low, synchronous) empties the queue; cell contents are not
//  cleared and need no clearing pass, since only occupied cells are read.
//  The result is shown for exactly one cycle; the receiver cannot stall it.
//
module min_priority_queue_coords
    import mpq_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int COORD_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // command transfer
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_action,
    input  logic [COORD_W-1:0]       i_coord_x,
    input  logic [COORD_W-1:0]       i_coord_y,
    input  logic signed [COST_W-1:0] i_cost,
    // result transfer
    output logic                     o_done,
    output logic [COORD_W-1:0]       o_out_x,
    output logic [COORD_W-1:0]       o_out_y,
    output logic signed [COST_W-1:0] o_out_cost,
    output logic [STATUS_W-1:0]      o_status,
    output logic [OCC_W-1:0]         o_occupancy,
    output logic                     o_is_empty
);

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    // sequencer: capture on start while idle, then issue the operation
    mpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_dp_status (dp_status),
        .o_cmd       (ctrl_cmd)
    );

    // cells, count and result registers
    mpq_datapath #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctrl_cmd),
        .o_dp_status (dp_status),
        .i_action    (i_action),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .i_cost      (i_cost),
        .o_done      (o_done),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_cost  (o_out_cost),
        .o_status    (o_status),
        .o_occupancy (o_occupancy),
        .o_is_empty  (o_is_empty)
    );

endmodule

[rtl/mpq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_ctrl
// Two-state sequencer: capture a command, then issue one datapath operation.
// ----------------------------------------------------------------------------
module mpq_ctrl
    import mpq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_dp_status i_dp_status,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.op   = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // pick the operation, folding in the full / empty faults
                if (i_dp_status.action == ACT_PUSH) begin
                    o_cmd.op = i_dp_status.full ? OP_PUSH_FULL : OP_PUSH;
                end else begin
                    o_cmd.op = i_dp_status.empty ? OP_POP_EMPTY : OP_POP;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state == S_EXEC);

endmodule

[rtl/mpq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_datapath
// Sorted shift array of entries with per-cell cost compare, entry count and
// result registers.
// ----------------------------------------------------------------------------
module mpq_datapath
    import mpq_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int COORD_BITS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_ctrl_cmd                  i_cmd,
    output t_dp_status                 o_dp_status,
    input  logic                       i_action,
    input  logic [COORD_W-1:0]         i_coord_x,
    input  logic [COORD_W-1:0]         i_coord_y,
    input  logic signed [COST_W-1:0]   i_cost,
    output logic                       o_done,
    output logic [COORD_W-1:0]         o_out_x,
    output logic [COORD_W-1:0]         o_out_y,
    output logic signed [COST_W-1:0]   o_out_cost,
    output logic [STATUS_W-1:0]        o_status,
    output logic [OCC_W-1:0]           o_occupancy,
    output logic                       o_is_empty
);

    localparam int CW = $clog2(CAPACITY + 1);

    // captured command
    logic                     r_action;
    logic [COORD_BITS-1:0]    r_in_x;
    logic [COORD_BITS-1:0]    r_in_y;
    logic signed [COST_W-1:0] r_in_cost;

    // entry cells
    logic [COORD_BITS-1:0]    r_ex [CAPACITY];
    logic [COORD_BITS-1:0]    r_ey [CAPACITY];
    logic signed [COST_W-1:0] r_ec [CAPACITY];
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;

    // set when cell moves one place toward the tail on a push
    logic [CAPACITY-1:0]      shift_up;

    logic                     r_done;
    logic [COORD_W-1:0]       r_out_x;
    logic [COORD_W-1:0]       r_out_y;
    logic signed [COST_W-1:0] r_out_cost;
    logic [STATUS_W-1:0]      r_status;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action  <= i_action;
            r_in_x    <= COORD_BITS'(i_coord_x);
            r_in_y    <= COORD_BITS'(i_coord_y);
            r_in_cost <= i_cost;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                     in_use;
            logic                     at_tail;
            logic                     from_prev;
            logic [COORD_BITS-1:0]    prev_x;
            logic [COORD_BITS-1:0]    prev_y;
            logic signed [COST_W-1:0] prev_c;
            logic [COORD_BITS-1:0]    next_x;
            logic [COORD_BITS-1:0]    next_y;
            logic signed [COST_W-1:0] next_c;

            assign in_use  = (CW'(g) < r_count);
            assign at_tail = (CW'(g) == r_count);

            // head moves only on a strictly greater cost; equal cost lands behind it
            if (g == 0) begin : g_head
                assign shift_up[g] = in_use && (r_ec[g] > r_in_cost);
                assign from_prev   = 1'b0;
                assign prev_x      = r_ex[g];
                assign prev_y      = r_ey[g];
                assign prev_c      = r_ec[g];
            end else begin : g_body
                assign shift_up[g] = in_use && (r_ec[g] >= r_in_cost);
                assign from_prev   = shift_up[g-1];
                assign prev_x      = r_ex[g-1];
                assign prev_y      = r_ey[g-1];
                assign prev_c      = r_ec[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign next_x = r_ex[g];
                assign next_y = r_ey[g];
                assign next_c = r_ec[g];
            end else begin : g_inner
                assign next_x = r_ex[g+1];
                assign next_y = r_ey[g+1];
                assign next_c = r_ec[g+1];
            end

            always_ff @(posedge i_clk) begin
                priority if (i_cmd.op == OP_PUSH && from_prev) begin
                    r_ex[g] <= prev_x;
                    r_ey[g] <= prev_y;
                    r_ec[g] <= prev_c;
                end else if (i_cmd.op == OP_PUSH && (shift_up[g] || at_tail)) begin
                    r_ex[g] <= r_in_x;
                    r_ey[g] <= r_in_y;
                    r_ec[g] <= r_in_cost;
                end else if (i_cmd.op == OP_POP) begin
                    r_ex[g] <= next_x;
                    r_ey[g] <= next_y;
                    r_ec[g] <= next_c;
                end else begin
                    r_ex[g] <= r_ex[g];
                    r_ey[g] <= r_ey[g];
                    r_ec[g] <= r_ec[g];
                end
            end
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        unique case (i_cmd.op)
            OP_PUSH:      n_count = r_count + CW'(1);
            OP_POP:       n_count = r_count - CW'(1);
            OP_NONE,
            OP_PUSH_FULL,
            OP_POP_EMPTY: n_count = r_count;
            default:      n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= (i_cmd.op != OP_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_x    <= '0;
        r_out_y    <= '0;
        r_out_cost <= '0;
        unique case (i_cmd.op)
            OP_POP: begin
                r_out_x    <= COORD_W'(r_ex[0]);
                r_out_y    <= COORD_W'(r_ey[0]);
                r_out_cost <= r_ec[0];
                r_status   <= STATUS_OK;
            end
            OP_PUSH:      r_status <= STATUS_OK;
            OP_PUSH_FULL: r_status <= STATUS_FULL;
            OP_POP_EMPTY: r_status <= STATUS_EMPTY;
            OP_NONE:      r_status <= STATUS_OK;
            default:      r_status <= STATUS_OK;
        endcase
    end

    assign o_dp_status.action = r_action;
    assign o_dp_status.full   = (r_count == CW'(CAPACITY));
    assign o_dp_status.empty  = (r_count == '0);

    // count holds steady through the result cycle, so report it directly
    assign o_done      = r_done;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_out_cost  = r_out_cost;
    assign o_status    = r_status;
    assign o_occupancy = OCC_W'(r_count);
    assign o_is_empty  = (r_count == '0);

endmodule

[rtl/mpq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_port_checker
// Port-level checks on command timing and result contents, bound to the top.
// ----------------------------------------------------------------------------
`include "min_priority_queue_coords_assert.svh"

module mpq_port_checker
    import mpq_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     o_done,
    input logic [COORD_W-1:0]       o_out_x,
    input logic [COORD_W-1:0]       o_out_y,
    input logic signed [COST_W-1:0] o_out_cost,
    input logic [STATUS_W-1:0]      o_status,
    input logic [OCC_W-1:0]         o_occupancy,
    input logic                     o_is_empty
);

    // a transfer locks out the next command for the execute cycle
    `MPQ_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_done)

    // every transfer yields its result after the execute state and the done register
    `MPQ_ASSERT_AFTER2(a_accept_done, i_clk, i_rst_n, start && !busy, o_done)

    // a faulted command returns no entry
    `MPQ_ASSERT_NOW(a_fault_zero, i_clk, i_rst_n, o_done && o_status != STATUS_OK, o_out_x == 0 && o_out_y == 0 && o_out_cost == 0)

    // a pop on empty leaves the queue empty
    `MPQ_ASSERT_NOW(a_empty_pop, i_clk, i_rst_n, o_done && o_status == STATUS_EMPTY, o_is_empty && o_occupancy == 0)

endmodule

bind min_priority_queue_coords mpq_port_checker u_mpq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_out_x     (o_out_x),
    .o_out_y     (o_out_y),
    .o_out_cost  (o_out_cost),
    .o_status    (o_status),
    .o_occupancy (o_occupancy),
    .o_is_empty  (o_is_empty)
);

[dv/mpq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_checker
// Watches the command and result channels of the min-priority queue, keeps
// a shadow copy of the sorted entry array, and compares every result
// strobe field by field with the oldest predicted reply.
// ----------------------------------------------------------------------------
module mpq_checker
    import mpq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_busy,
    input  logic                     i_action,
    input  logic [COORD_W-1:0]       i_coord_x,
    input  logic [COORD_W-1:0]       i_coord_y,
    input  logic signed [COST_W-1:0] i_cost,
    input  logic                     i_done,
    input  logic [COORD_W-1:0]       i_out_x,
    input  logic [COORD_W-1:0]       i_out_y,
    input  logic signed [COST_W-1:0] i_out_cost,
    input  logic [STATUS_W-1:0]      i_status,
    input  logic [OCC_W-1:0]         i_occupancy,
    input  logic                     i_is_empty,
    output int                       o_pending,
    output int                       o_fail_count
);

    typedef struct packed {
        logic [COORD_W-1:0]       x;
        logic [COORD_W-1:0]       y;
        logic signed [COST_W-1:0] cost;
        logic [STATUS_W-1:0]      status;
        logic [OCC_W-1:0]         occupancy;
        logic                     is_empty;
    } t_reply;

    // shadow of the sorted array, lowest cost at slot 0
    logic [COORD_W-1:0]       shadow_x    [CAPACITY];
    logic [COORD_W-1:0]       shadow_y    [CAPACITY];
    logic signed [COST_W-1:0] shadow_cost [CAPACITY];
    int                       shadow_count;
    t_reply                   replies_due [$];
    int                       fails = 0;

    // Apply one command to the shadow array and work out its reply.
    task automatic apply_queue_op(
        input  logic                     act,
        input  logic [COORD_W-1:0]       x,
        input  logic [COORD_W-1:0]       y,
        input  logic signed [COST_W-1:0] cost,
        output t_reply                   reply
    );
        int slot;
        reply        = '0;
        reply.status = STATUS_OK;
        if (act == ACT_PUSH) begin
            if (shadow_count >= CAPACITY) begin
                reply.status = STATUS_FULL;
            end else begin
                // cheaper than the head goes in front; else before the first
                // entry behind the head whose cost is not less, else at the back
                slot = shadow_count;
                if (shadow_count == 0 || shadow_cost[0] > cost) begin
                    slot = 0;
                end else begin
                    for (int i = shadow_count - 1; i >= 1; i--)
                        if (shadow_cost[i] >= cost) slot = i;
                end
                for (int i = shadow_count; i > slot; i--) begin
                    shadow_x[i]    = shadow_x[i-1];
                    shadow_y[i]    = shadow_y[i-1];
                    shadow_cost[i] = shadow_cost[i-1];
                end
                shadow_x[slot]    = x;
                shadow_y[slot]    = y;
                shadow_cost[slot] = cost;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                reply.status = STATUS_EMPTY;
            end else begin
                reply.x    = shadow_x[0];
                reply.y    = shadow_y[0];
                reply.cost = shadow_cost[0];
                for (int i = 0; i < shadow_count - 1; i++) begin
                    shadow_x[i]    = shadow_x[i+1];
                    shadow_y[i]    = shadow_y[i+1];
                    shadow_cost[i] = shadow_cost[i+1];
                end
                shadow_count--;
            end
        end
        reply.occupancy = OCC_W'(shadow_count);
        reply.is_empty  = (shadow_count == 0);
    endtask

    task automatic check_field(input string what, input longint want, input longint got);
        if (want != got) begin
            $display("%0t mpq_checker: %s mismatch, expected %0d actual %0d",
                     $time, what, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_reply due;
        t_reply fresh;
        if (!i_rst_n) begin
            shadow_count = 0;
            replies_due.delete();
        end else begin
            // retire the oldest reply before taking a new command in
            if (i_done) begin
                if (replies_due.size() == 0) begin
                    $display("%0t mpq_checker: stray result, expected none actual status %0d",
                             $time, i_status);
                    fails++;
                end else begin
                    due = replies_due.pop_front();
                    check_field("out_x", due.x, i_out_x);
                    check_field("out_y", due.y, i_out_y);
                    check_field("out_cost", due.cost, i_out_cost);
                    check_field("status", due.status, i_status);
                    check_field("occupancy", due.occupancy, i_occupancy);
                    check_field("is_empty", due.is_empty, i_is_empty);
                end
            end
            if (i_start && !i_busy) begin
                apply_queue_op(i_action, i_coord_x, i_coord_y, i_cost, fresh);
                replies_due.push_back(fresh);
            end
        end
        o_pending    <= replies_due.size();
        o_fail_count <= fails;
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives push and pop commands into the min-priority queue: a directed
// opening over extreme costs, coordinates, ties and a pop on empty, then
// random fill, drain and mixed phases, all sent in bursts with random gaps.
// Checking is done by mpq_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import mpq_pkg::*;

    localparam int DEPTH      = 64;
    localparam int RANDOM_OPS = 1950;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic                     cmd_action;
    logic [COORD_W-1:0]       cmd_x;
    logic [COORD_W-1:0]       cmd_y;
    logic signed [COST_W-1:0] cmd_cost;
    logic                     res_done;
    logic [COORD_W-1:0]       res_x;
    logic [COORD_W-1:0]       res_y;
    logic signed [COST_W-1:0] res_cost;
    logic [STATUS_W-1:0]      res_status;
    logic [OCC_W-1:0]         res_occupancy;
    logic                     res_is_empty;
    int                       pending;
    int                       fail_count;

    // commands left in the current burst before the sender may pause
    int                       burst_left;

    min_priority_queue_coords #(
        .CAPACITY  (DEPTH),
        .COORD_BITS(COORD_W)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_action   (cmd_action),
        .i_coord_x  (cmd_x),
        .i_coord_y  (cmd_y),
        .i_cost     (cmd_cost),
        .o_done     (res_done),
        .o_out_x    (res_x),
        .o_out_y    (res_y),
        .o_out_cost (res_cost),
        .o_status   (res_status),
        .o_occupancy(res_occupancy),
        .o_is_empty (res_is_empty)
    );

    mpq_checker #(
        .CAPACITY(DEPTH)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_action    (cmd_action),
        .i_coord_x   (cmd_x),
        .i_coord_y   (cmd_y),
        .i_cost      (cmd_cost),
        .i_done      (res_done),
        .i_out_x     (res_x),
        .i_out_y     (res_y),
        .i_out_cost  (res_cost),
        .i_status    (res_status),
        .i_occupancy (res_occupancy),
        .i_is_empty  (res_is_empty),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Give up well past the slowest correct run.
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // Cost mix: half from a narrow band so that ties with the head and with
    // other entries are common, some extremes, the rest full 32-bit random.
    function automatic logic signed [COST_W-1:0] pick_cost();
        int sel;
        int band;
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            band = int'($urandom_range(0, 8)) - 4;
            return band;
        end
        if (sel == 5) begin
            case ($urandom_range(0, 3))
                0:       return 32'sh7FFF_FFFF;
                1:       return 32'sh8000_0000;
                2:       return 32'sh0000_0000;
                default: return 32'shFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // Present one command and hold it until it transfers. Pause first when
    // the current burst is used up; lower start only for a real gap so that
    // it is never dropped and raised in the same step.
    task automatic send_op(
        input logic                     act,
        input logic [COORD_W-1:0]       x,
        input logic [COORD_W-1:0]       y,
        input logic signed [COST_W-1:0] cost
    );
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start      <= 1'b1;
        cmd_action <= act;
        cmd_x      <= x;
        cmd_y      <= y;
        cmd_cost   <= cost;
        // busy read right after the edge is the value the block sampled
        do @(posedge i_clk); while (busy);
    endtask

    initial begin
        int   sent;
        int   run;
        int   push_pct;
        logic act;

        // Drive every input to a known value from time zero.
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        cmd_action <= ACT_PUSH;
        cmd_x      <= '0;
        cmd_y      <= '0;
        cmd_cost   <= '0;
        burst_left = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening.
        // Pop on an empty queue right after reset.
        send_op(ACT_POP, 8'hFF, 8'hFF, 32'sh7FFF_FFFF);
        // First push into an empty queue, then a tie with the head.
        send_op(ACT_PUSH, 8'h00, 8'h00, 32'sh0000_0000);
        send_op(ACT_PUSH, 8'hFF, 8'hFF, 32'sh0000_0000);
        // Cheaper than the head: goes in front.
        send_op(ACT_PUSH, 8'h01, 8'h02, 32'shFFFF_FFFF);
        // Largest cost lands at the back; smallest goes in front.
        send_op(ACT_PUSH, 8'hAA, 8'h55, 32'sh7FFF_FFFF);
        send_op(ACT_PUSH, 8'h55, 8'hAA, 32'sh8000_0000);
        // Tie with an entry behind the head: goes before it.
        send_op(ACT_PUSH, 8'h03, 8'h04, 32'shFFFF_FFFF);
        // Tie with the head again, at the most negative cost.
        send_op(ACT_PUSH, 8'h05, 8'h06, 32'sh8000_0000);
        // Drain all seven, with junk on the unused fields, and pop twice more.
        repeat (9) send_op(ACT_POP, COORD_W'($urandom), COORD_W'($urandom), $urandom);

        // Random phases: fill runs push the queue against its capacity so
        // that full rejections show up, drain runs empty it, mixed runs
        // stir the middle.
        sent = 0;
        while (sent < RANDOM_OPS) begin
            case ($urandom_range(0, 2))
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            run = $urandom_range(30, 160);
            repeat (run) begin
                act = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
                send_op(act, COORD_W'($urandom), COORD_W'($urandom), pick_cost());
                sent++;
            end
        end

        // Stop sending, let every reply come back, then allow a few more
        // cycles for anything stray.
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
